// File: rtl/sha_pkg.sv
// Package: SHA-256 constants, round tables and bit functions.
`default_nettype none
package sha_pkg;

    localparam int WORD_W     = 32;
    localparam int BLK_WORDS  = 16;
    localparam int BLK_AW     = 4;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 64;
    localparam int ROUNDS     = 64;
    localparam int RND_W      = 7;
    localparam int PAD_POS    = 56;

    typedef logic [WORD_W-1:0] word_t;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

// File: rtl/sha256_hash_engine_core.sv
// Top level: byte-fed SHA-256 engine with block buffer RAM and iterative rounds.
//
//  channel | dir | tdata           | tuser          | tlast
//  s_      | in  | byte_value[7:0] | has_byte       | last_item
//  m_      | out | digest_word     | word_index[2:0]| last_word
//
// One data byte is taken per cycle while s_tready is high; a byte that fills
// a block starts a compression (prefetch, 64 rounds plus a schedule step,
// hash update) by the single round unit. The final item is followed by
// padding, one byte per cycle between block compressions (one or two), then
// eight output transactions. Reset loads the initial hash and clears the
// counters. s_tready is low during padding, compression and digest output.
`default_nettype none
module sha256_hash_engine_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] byte_value
    input  wire logic         s_tuser,   // [0] has_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // [31:0] digest_word
    output logic [2:0]        m_tuser,   // [2:0] word_index
    output logic              m_tlast
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_HUPD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [5:0]        pos_reg, pos_next;
    logic [23:0]       part_reg, part_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              pad_act_reg, pad_act_next;
    logic              mark_reg, mark_next;
    logic [2:0]        len_cnt_reg, len_cnt_next;
    logic              fin_reg, fin_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [2:0]        oidx_reg, oidx_next;
    word_t             hash_reg [8];
    word_t             var_reg  [8];
    word_t             win_reg  [BLK_WORDS];

    logic              s_hs, m_hs;
    logic              put_vld;
    logic [BYTE_W-1:0] put_byte;
    logic [5:0]        put_pos1;
    logic              ram_we;
    logic [BLK_AW-1:0] ram_raddr;
    word_t             ram_rdata;
    word_t             w_new, t1, t2;
    logic [5:0]        kidx;
    logic [2:0]        len_sh;
    logic              block_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign s_hs     = s_tvalid && s_tready;
    assign m_hs     = m_tvalid && m_tready;
    assign m_tdata  = hash_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

    // select the byte to pack: input byte or padding byte
    assign len_sh = 3'd7 - len_cnt_reg;
    always_comb begin
        put_vld  = 1'b0;
        put_byte = s_tdata;
        if (state_reg == ST_IDLE) begin
            put_vld = s_hs && s_tuser;
        end else if (state_reg == ST_PAD) begin
            put_vld = 1'b1;
            if (!mark_reg) begin
                put_byte = PAD_MARK;
            end else if (pos_reg != 6'(PAD_POS) && len_cnt_reg == 3'd0) begin
                put_byte = '0;
            end else begin
                put_byte = count_reg[{len_sh, 3'b000} +: BYTE_W];
            end
        end
    end

    assign put_pos1   = pos_reg + 6'd1;
    assign block_done = put_vld && (pos_reg == 6'd63);
    // writes happen only while packing; reads only during compression
    assign ram_we     = put_vld && (pos_reg[1:0] == 2'd3);
    assign ram_raddr  = (state_reg == ST_RND) ? BLK_AW'(rnd_reg + 7'd1) : '0;

    sha_ram #(.WIDTH(WORD_W), .DEPTH(BLK_WORDS)) u_blk_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg[5:2]),
        .wdata ({part_reg, put_byte}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // schedule word and round datapath
    assign kidx  = 6'(rnd_reg - 7'd1);
    assign w_new = (rnd_reg < 7'(BLK_WORDS)) ? ram_rdata
                 : ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign t1 = var_reg[7] + bsig1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + ROUND_K[kidx] + win_reg[15];
    assign t2 = bsig0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    // control next state
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        part_next    = part_reg;
        count_next   = count_reg;
        pad_act_next = pad_act_reg;
        mark_next    = mark_reg;
        len_cnt_next = len_cnt_reg;
        fin_next     = fin_reg;
        rnd_next     = rnd_reg;
        oidx_next    = oidx_reg;

        if (put_vld) begin
            pos_next  = put_pos1;
            part_next = {part_reg[15:0], put_byte};
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    if (s_tuser) begin
                        count_next = count_reg + LEN_W'(8);
                    end
                    if (s_tlast) begin
                        pad_act_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                    if (block_done) begin
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PAD: begin
                if (!mark_reg) begin
                    mark_next = 1'b1;
                end else if (pos_reg != 6'(PAD_POS) || len_cnt_reg != 3'd0) begin
                    if (pos_reg == 6'(PAD_POS) || len_cnt_reg != 3'd0) begin
                        len_cnt_next = len_cnt_reg + 3'd1;
                        if (len_cnt_reg == 3'd7) begin
                            fin_next = 1'b1;
                        end
                    end
                end else begin
                    len_cnt_next = 3'd1;
                end
                if (block_done) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                rnd_next   = '0;
                state_next = ST_RND;
            end
            ST_RND: begin
                if (rnd_reg == 7'(ROUNDS)) begin
                    state_next = ST_HUPD;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_HUPD: begin
                if (fin_reg) begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end else if (pad_act_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_hs) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        state_next   = ST_IDLE;
                        pos_next     = '0;
                        count_next   = '0;
                        pad_act_next = 1'b0;
                        mark_next    = 1'b0;
                        len_cnt_next = '0;
                        fin_next     = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            count_reg   <= '0;
            pad_act_reg <= 1'b0;
            mark_reg    <= 1'b0;
            len_cnt_reg <= '0;
            fin_reg     <= 1'b0;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            pad_act_reg <= pad_act_next;
            mark_reg    <= mark_next;
            len_cnt_reg <= len_cnt_next;
            fin_reg     <= fin_next;
            rnd_reg     <= rnd_next;
            oidx_reg    <= oidx_next;
        end
    end

    // partial word and schedule window
    always_ff @(posedge aclk) begin
        part_reg <= part_next;
        if (state_reg == ST_RND && rnd_reg != 7'(ROUNDS)) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLK_WORDS-1] <= w_new;
        end
    end

    // working variables: load, advance one round per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PRE) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= hash_reg[i];
            end
        end else if (state_reg == ST_RND && rnd_reg != '0) begin
            var_reg[0] <= t1 + t2;
            var_reg[1] <= var_reg[0];
            var_reg[2] <= var_reg[1];
            var_reg[3] <= var_reg[2];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[5] <= var_reg[4];
            var_reg[6] <= var_reg[5];
            var_reg[7] <= var_reg[6];
        end
    end

    // running hash: reset to initial values (also after the last digest word), accumulate after each block
    always_ff @(posedge aclk) begin
        if (!aresetn || (m_hs && oidx_reg == 3'd7)) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= iv_word(3'(i));
            end
        end else if (state_reg == ST_HUPD) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !(state_reg == ST_RND || state_reg == ST_PRE))
        else $error("block RAM written during compression");
    a_msg_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_hs && m_tlast) |=> (pos_reg == '0 && count_reg == '0 && s_tready))
        else $error("engine not cleared after digest");
    a_rnd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RND) |-> (rnd_reg <= 7'(ROUNDS)))
        else $error("round counter overrun");

endmodule
`default_nettype wire

// File: rtl/sha_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
